>>> rtl/servo_drive_enable_sequencer_core_macros.svh
// Assertion macros used by the servo drive enable sequencer RTL.
`ifndef SERVO_DRIVE_ENABLE_SEQUENCER_CORE_MACROS_SVH
`define SERVO_DRIVE_ENABLE_SEQUENCER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Checks an implication on every clock edge outside reset.
`define SDES_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdes assertion failed");
// Checks a next-cycle implication on every clock edge outside reset.
`define SDES_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdes assertion failed");
`else
`define SDES_ASSERT_IMP(lbl, ante, cons)
`define SDES_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/sdes_pkg.sv
package sdes_pkg;

    localparam logic [15:0] CTRL_SHUTDN      = 16'h0006;
    localparam logic [15:0] CTRL_SWITCHON    = 16'h0007;
    localparam logic [15:0] CTRL_ENABLE_OP   = 16'h000F;
    localparam logic [15:0] CTRL_FAULT_CLEAR = 16'h0080;

    localparam logic signed [7:0] MODE_MAX = 8'sd10;
    localparam logic signed [7:0] MODE_CSP = 8'sd8;
    localparam logic signed [7:0] MODE_CSV = 8'sd9;
    localparam logic signed [7:0] MODE_CST = 8'sd10;

    // Status word bit positions.
    localparam int STAT_READY    = 0;
    localparam int STAT_SWON     = 1;
    localparam int STAT_OPEN     = 2;
    localparam int STAT_FAULT    = 3;
    localparam int STAT_QSTOP    = 5;
    localparam int STAT_DISABLED = 6;

    typedef enum logic [2:0] {
        ST_START    = 3'd0,
        ST_UNDEF    = 3'd1,
        ST_DISABLED = 3'd2,
        ST_READY    = 3'd3,
        ST_SWON     = 3'd4,
        ST_ENABLED  = 3'd5,
        ST_QSTOP    = 3'd6,
        ST_FAULT    = 3'd7
    } drive_state_t;

    typedef enum logic [1:0] {
        CFG_AUTO_CLEAR_FAULT   = 2'd0,
        CFG_AUTO_TRANSITIONS   = 2'd1,
        CFG_MODE_REQUEST       = 2'd2,
        CFG_FAULT_RESET_SOURCE = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic              auto_clear_fault;
        logic              auto_transitions;
        logic signed [7:0] mode_request;
        logic              fault_reset_source_enabled;
    } cfg_t;

    typedef struct packed {
        logic [15:0]       drive_status;
        logic signed [7:0] mode_display;
        logic              fault_reset_request;
        logic              bus_operational;
    } in_t;

    typedef struct packed {
        logic [15:0] ctrl_cmd;
        logic        ctrl_cmd_valid;
        logic [3:0]  mode_command;
        logic        mode_command_valid;
        logic        hold_position;
        logic        hold_velocity;
        logic        hold_torque;
        logic [2:0]  drive_state_out;
        logic        drive_ready;
    } out_t;

    function automatic drive_state_t decode_state(input logic [15:0] sw);
        drive_state_t st;
        if (sw[STAT_FAULT]) begin
            st = ST_FAULT;
        end else if (sw[STAT_DISABLED]) begin
            st = ST_DISABLED;
        end else if (sw[STAT_READY] && sw[STAT_SWON] && sw[STAT_OPEN]) begin
            st = sw[STAT_QSTOP] ? ST_ENABLED : ST_QSTOP;
        end else if (sw[STAT_READY] && sw[STAT_SWON]) begin
            st = ST_SWON;
        end else if (sw[STAT_READY]) begin
            st = ST_READY;
        end else begin
            st = ST_UNDEF;
        end
        return st;
    endfunction

endpackage

>>> rtl/sdes_regs.sv
module sdes_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  sdes_pkg::cfg_idx_t cfg_index,
    input  logic [7:0]       cfg_wdata,
    output sdes_pkg::cfg_t   cfg
);
    import sdes_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_AUTO_CLEAR_FAULT:   cfg_next.auto_clear_fault = cfg_wdata[0];
                CFG_AUTO_TRANSITIONS:   cfg_next.auto_transitions = cfg_wdata[0];
                CFG_MODE_REQUEST:       cfg_next.mode_request = $signed(cfg_wdata);
                CFG_FAULT_RESET_SOURCE: cfg_next.fault_reset_source_enabled = cfg_wdata[0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_clear_fault           <= 1'b0;
            cfg_reg.auto_transitions           <= 1'b0;
            cfg_reg.mode_request               <= -8'sd1;
            cfg_reg.fault_reset_source_enabled <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/sdes_seq.sv
module sdes_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  sdes_pkg::cfg_t cfg,
    input  sdes_pkg::in_t  item,
    output sdes_pkg::out_t result
);
    import sdes_pkg::*;

    `include "servo_drive_enable_sequencer_core_macros.svh"

    // The stored state always equals the state left by the previous word, so it
    // also serves as the previous drive state for the ready flag.
    drive_state_t      drive_state_reg;
    drive_state_t      drive_state_next;
    logic [15:0]       previous_status_reg;
    logic signed [7:0] shown_mode_reg;
    logic              reset_request_seen_reg;
    logic              reset_request_seen_next;
    logic              reset_pending_reg;
    logic              reset_pending_next;

    logic              pending_mid;
    logic              enabled;
    logic              mode_ok;
    logic              status_changed;

    always_comb
    begin
        reset_request_seen_next = reset_request_seen_reg;
        pending_mid             = reset_pending_reg;

        // Rising edge on the host fault-reset request arms a one-shot reset.
        if (item.bus_operational && cfg.fault_reset_source_enabled)
        begin
            if (!item.fault_reset_request)
            begin
                reset_request_seen_next = 1'b0;
            end
            if (!reset_request_seen_next && item.fault_reset_request)
            begin
                reset_request_seen_next = 1'b1;
                pending_mid             = 1'b1;
            end
        end

        reset_pending_next    = pending_mid;
        result.ctrl_cmd_valid = item.bus_operational && cfg.auto_transitions;
        result.ctrl_cmd       = '0;
        if (result.ctrl_cmd_valid)
        begin
            case (drive_state_reg)
                ST_READY:
                    result.ctrl_cmd = CTRL_SWITCHON;
                ST_SWON, ST_ENABLED, ST_QSTOP:
                    result.ctrl_cmd = CTRL_ENABLE_OP;
                ST_FAULT:
                begin
                    if (cfg.auto_clear_fault || pending_mid)
                    begin
                        result.ctrl_cmd    = CTRL_FAULT_CLEAR;
                        reset_pending_next = 1'b0;
                    end
                    else
                    begin
                        result.ctrl_cmd = CTRL_SHUTDN;
                    end
                end
                default:
                    result.ctrl_cmd = CTRL_SHUTDN;
            endcase
        end

        mode_ok = !cfg.mode_request[7] && (cfg.mode_request <= MODE_MAX);
        result.mode_command       = mode_ok ? cfg.mode_request[3:0] : 4'd0;
        result.mode_command_valid = mode_ok;

        enabled = (drive_state_reg == ST_ENABLED);
        result.hold_position = !(enabled && (shown_mode_reg == MODE_CSP));
        result.hold_velocity = !(enabled && (shown_mode_reg == MODE_CSV));
        result.hold_torque   = !(enabled && (shown_mode_reg == MODE_CST));

        // The drive state is decoded again only when the status word changes.
        status_changed   = (item.drive_status != previous_status_reg);
        drive_state_next = status_changed ? decode_state(item.drive_status) : drive_state_reg;

        result.drive_state_out = drive_state_next;
        result.drive_ready     = (drive_state_next == ST_ENABLED) && enabled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_state_reg        <= ST_START;
            previous_status_reg    <= '0;
            shown_mode_reg         <= '0;
            reset_request_seen_reg <= 1'b0;
            reset_pending_reg      <= 1'b0;
        end
        else if (step)
        begin
            drive_state_reg        <= drive_state_next;
            previous_status_reg    <= item.drive_status;
            shown_mode_reg         <= item.mode_display;
            reset_request_seen_reg <= reset_request_seen_next;
            reset_pending_reg      <= reset_pending_next;
        end
    end

    `SDES_ASSERT_NXT(a_pending_off_bus, step && !item.bus_operational, $stable(reset_pending_reg))
    `SDES_ASSERT_NXT(a_state_held_same_status, step && !status_changed, $stable(drive_state_reg))
    `SDES_ASSERT_NXT(a_clear_once, step && result.ctrl_cmd == CTRL_FAULT_CLEAR, !reset_pending_reg)
    `SDES_ASSERT_IMP(a_cmd_zero_idle, !result.ctrl_cmd_valid, result.ctrl_cmd == 16'd0)

endmodule

>>> rtl/servo_drive_enable_sequencer_core.sv
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  ----------------------------
// in        input      in_valid / in_ready    in_data  (sdes_pkg::in_t)
// out       output     out_valid / out_ready  out_data (sdes_pkg::out_t)
// cfg       input      cfg_we (no wait)       cfg_index, cfg_wdata
//
// One word can be accepted every cycle while the output is not stalled. A word waits in the
// input register and moves to the result register when the sequencer steps, and leaves from there.
// The drive state and edge-detect registers update as a word leaves the input register.
// While a result waits with out_ready low, both registers hold and in_ready drops once
// the input register is full. Reset clears the valid flags and the sequencer state, not the
// data registers, and loads the register defaults (mode request reads as -1).
module servo_drive_enable_sequencer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sdes_pkg::in_t      in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sdes_pkg::out_t     out_data,
    input  logic               cfg_we,
    input  sdes_pkg::cfg_idx_t cfg_index,
    input  logic [7:0]         cfg_wdata
);
    import sdes_pkg::*;

    cfg_t cfg;
    out_t result;

    logic s1_valid_reg;
    logic s1_valid_next;
    in_t  s1_data_reg;
    logic out_valid_reg;
    logic out_valid_next;
    out_t out_data_reg;

    logic out_free;
    logic step;
    logic in_accept;

    sdes_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sdes_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cfg    (cfg),
        .item   (s1_data_reg),
        .result (result)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign step      = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= in_data;
        end
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> dv/servo_drive_enable_sequencer_core_test.sv
`timescale 1ns / 1ps

module servo_drive_enable_sequencer_core_test;
    import sdes_pkg::*;

    localparam logic [15:0] STATUS_DISABLED = 16'h0040;
    localparam logic [15:0] STATUS_READY    = 16'h0021;
    localparam logic [15:0] STATUS_SWON     = 16'h0023;
    localparam logic [15:0] STATUS_ENABLED  = 16'h0027;
    localparam logic [15:0] STATUS_QSTOP    = 16'h0007;
    localparam logic [15:0] STATUS_FAULT    = 16'h0008;
    // Status bits that play no part in the state decode.
    localparam logic [15:0] STATUS_SPARE    = 16'hFF90;
    localparam int          DRAIN_GUARD     = 20000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_t        in_data;
    logic       out_valid;
    logic       out_ready;
    out_t       out_data;
    logic       cfg_we;
    cfg_idx_t   cfg_index;
    logic [7:0] cfg_wdata;

    servo_drive_enable_sequencer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    in_t  bus_cycles_to_send[$];
    out_t predicted_outputs[$];
    int   error_count = 0;
    bit   word_taken = 0;
    bit   steady_flow = 0;
    int   send_gap = 0;
    int   stall_left = 0;

    // Copy of the registers and of the sequencer state.
    cfg_t              reg_shadow;
    drive_state_t      model_state;
    drive_state_t      model_prev_state;
    logic [15:0]       model_prev_status;
    logic signed [7:0] model_shown_mode;
    bit                model_req_seen;
    bit                model_reset_armed;

    // Stimulus state: where the simulated drive sits in its sequence.
    drive_state_t sim_stage = ST_DISABLED;
    bit           host_req = 0;

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    function automatic drive_state_t classify_status(input logic [15:0] sw);
        logic [2:0] low_bits;
        low_bits = {sw[STAT_OPEN], sw[STAT_SWON], sw[STAT_READY]};
        if (sw[STAT_FAULT])
            return ST_FAULT;
        if (sw[STAT_DISABLED])
            return ST_DISABLED;
        case (low_bits)
            3'b111:         return sw[STAT_QSTOP] ? ST_ENABLED : ST_QSTOP;
            3'b011:         return ST_SWON;
            3'b001, 3'b101: return ST_READY;
            default:        return ST_UNDEF;
        endcase
    endfunction

    // Commands come from the state of earlier cycles; the state is updated after.
    task automatic step_drive_model(input in_t w, output out_t r);
        logic              was_enabled;
        logic signed [7:0] req_mode;
        was_enabled = (model_state == ST_ENABLED);
        req_mode = reg_shadow.mode_request;
        r = '0;
        if (w.bus_operational) begin
            if (reg_shadow.fault_reset_source_enabled) begin
                if (!w.fault_reset_request)
                    model_req_seen = 0;
                else if (!model_req_seen) begin
                    model_req_seen = 1;
                    model_reset_armed = 1;
                end
            end
            if (reg_shadow.auto_transitions) begin
                r.ctrl_cmd_valid = 1'b1;
                case (model_state)
                    ST_READY:                      r.ctrl_cmd = CTRL_SWITCHON;
                    ST_SWON, ST_ENABLED, ST_QSTOP: r.ctrl_cmd = CTRL_ENABLE_OP;
                    ST_FAULT:
                    begin
                        if (reg_shadow.auto_clear_fault || model_reset_armed) begin
                            model_reset_armed = 0;
                            r.ctrl_cmd = CTRL_FAULT_CLEAR;
                        end else begin
                            r.ctrl_cmd = CTRL_SHUTDN;
                        end
                    end
                    default:                       r.ctrl_cmd = CTRL_SHUTDN;
                endcase
            end
        end
        if (req_mode >= 0 && req_mode <= MODE_MAX) begin
            r.mode_command_valid = 1'b1;
            r.mode_command = req_mode[3:0];
        end
        r.hold_position = !(model_shown_mode == MODE_CSP && was_enabled);
        r.hold_velocity = !(model_shown_mode == MODE_CSV && was_enabled);
        r.hold_torque   = !(model_shown_mode == MODE_CST && was_enabled);

        model_shown_mode = w.mode_display;
        if (w.drive_status != model_prev_status)
            model_state = classify_status(w.drive_status);
        r.drive_state_out = model_state;
        r.drive_ready = (model_state == ST_ENABLED) && (model_prev_state == ST_ENABLED);
        model_prev_status = w.drive_status;
        model_prev_state = model_state;
    endtask

    function automatic int pick_gap();
        int roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 96)
            return $urandom_range(4, 9);
        else
            return $urandom_range(10, 40);
    endfunction

    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || word_taken) begin
                word_taken = 0;
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (bus_cycles_to_send.size() > 0) begin
                    in_data <= bus_cycles_to_send.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Results are checked before the new word is predicted, all in one process.
    always @(posedge clk) begin
        out_t want;
        out_t next_result;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (predicted_outputs.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = predicted_outputs.pop_front();
                    compare_field("ctrl_cmd", out_data.ctrl_cmd, want.ctrl_cmd);
                    compare_field("ctrl_cmd_valid", out_data.ctrl_cmd_valid,
                                  want.ctrl_cmd_valid);
                    compare_field("mode_command", out_data.mode_command, want.mode_command);
                    compare_field("mode_command_valid", out_data.mode_command_valid,
                                  want.mode_command_valid);
                    compare_field("hold_position", out_data.hold_position,
                                  want.hold_position);
                    compare_field("hold_velocity", out_data.hold_velocity,
                                  want.hold_velocity);
                    compare_field("hold_torque", out_data.hold_torque, want.hold_torque);
                    compare_field("drive_state_out", out_data.drive_state_out,
                                  want.drive_state_out);
                    compare_field("drive_ready", out_data.drive_ready, want.drive_ready);
                end
            end
            if (in_valid && in_ready) begin
                step_drive_model(in_data, next_result);
                predicted_outputs.push_back(next_result);
                word_taken = 1;
            end
        end
    end

    task automatic set_register(input cfg_idx_t idx, input logic [7:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_AUTO_CLEAR_FAULT:   reg_shadow.auto_clear_fault = value[0];
            CFG_AUTO_TRANSITIONS:   reg_shadow.auto_transitions = value[0];
            CFG_MODE_REQUEST:       reg_shadow.mode_request = value;
            CFG_FAULT_RESET_SOURCE: reg_shadow.fault_reset_source_enabled = value[0];
            default:                ;
        endcase
    endtask

    task automatic apply_settings(input cfg_t c);
        set_register(CFG_AUTO_CLEAR_FAULT, {7'd0, c.auto_clear_fault});
        set_register(CFG_AUTO_TRANSITIONS, {7'd0, c.auto_transitions});
        set_register(CFG_MODE_REQUEST, c.mode_request);
        set_register(CFG_FAULT_RESET_SOURCE, {7'd0, c.fault_reset_source_enabled});
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((bus_cycles_to_send.size() > 0 || in_valid || predicted_outputs.size() > 0)
               && guard < DRAIN_GUARD) begin
            @(negedge clk);
            guard++;
        end
        if (guard >= DRAIN_GUARD) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      predicted_outputs.size()));
            predicted_outputs.delete();
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic push_word(input logic [15:0] sw, input logic signed [7:0] md,
                             input logic req, input logic op);
        in_t w;
        w.drive_status = sw;
        w.mode_display = md;
        w.fault_reset_request = req;
        w.bus_operational = op;
        bus_cycles_to_send.push_back(w);
    endtask

    function automatic logic [15:0] status_for(input drive_state_t s);
        case (s)
            ST_READY:   return STATUS_READY;
            ST_SWON:    return STATUS_SWON;
            ST_ENABLED: return STATUS_ENABLED;
            ST_QSTOP:   return STATUS_QSTOP;
            ST_FAULT:   return STATUS_FAULT;
            default:    return STATUS_DISABLED;
        endcase
    endfunction

    function automatic drive_state_t next_stage(input drive_state_t s);
        int roll;
        roll = $urandom_range(0, 9);
        case (s)
            ST_DISABLED: return ST_READY;
            ST_READY:    return ST_SWON;
            ST_SWON:     return ST_ENABLED;
            ST_ENABLED:  return (roll < 6) ? ST_ENABLED : (roll < 8) ? ST_QSTOP : ST_FAULT;
            ST_QSTOP:    return (roll < 5) ? ST_DISABLED : ST_FAULT;
            default:     return ST_DISABLED;
        endcase
    endfunction

    // Mostly a drive walking through its enable sequence, with some raw noise.
    task automatic queue_drive_traffic(input int count);
        logic [15:0]       sw;
        logic signed [7:0] md;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                push_word(16'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                if ($urandom_range(0, 2) == 0)
                    sim_stage = next_stage(sim_stage);
                sw = status_for(sim_stage);
                if ($urandom_range(0, 6) == 0)
                    sw = sw | (16'($urandom) & STATUS_SPARE);
                if ($urandom_range(0, 4) == 0)
                    md = 8'($urandom);
                else
                    md = MODE_CSP + 8'($urandom_range(0, 2));
                if ($urandom_range(0, 4) == 0)
                    host_req = ~host_req;
                push_word(sw, md, host_req, $urandom_range(0, 19) != 0);
            end
        end
    endtask

    task automatic run_random_phase(input cfg_t c, input int count, input bit calm,
                                    input bit pause_midway);
        apply_settings(c);
        steady_flow = calm;
        queue_drive_traffic(count / 2);
        // Let the pipeline run completely dry before sending the rest.
        if (pause_midway)
            wait_idle();
        queue_drive_traffic(count - count / 2);
        wait_idle();
        steady_flow = 0;
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_AUTO_CLEAR_FAULT;
        cfg_wdata = '0;
        reg_shadow = '{1'b0, 1'b0, -8'sd1, 1'b0};
        model_state = ST_START;
        model_prev_state = ST_START;
        model_prev_status = '0;
        model_shown_mode = '0;
        model_req_seen = 0;
        model_reset_armed = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        apply_settings('{1'b0, 1'b1, 8'sd8, 1'b1});
        // A first status of zero matches the reset value, so the state stays at start.
        push_word(16'h0000, 8'sd0, 1'b0, 1'b1);
        push_word(16'h0000, 8'sd0, 1'b0, 1'b1);
        push_word(16'hFFFF, -8'sd128, 1'b1, 1'b1);
        push_word(16'hFFFF, 8'sd127, 1'b1, 1'b1);
        push_word(STATUS_FAULT, 8'sd0, 1'b1, 1'b1);
        push_word(STATUS_FAULT, 8'sd0, 1'b0, 1'b1);
        push_word(STATUS_FAULT, 8'sd0, 1'b1, 1'b0);
        push_word(STATUS_FAULT, 8'sd0, 1'b1, 1'b1);
        push_word(STATUS_DISABLED, 8'sd0, 1'b0, 1'b1);
        // The request arrives outside fault and stays pending until the next fault.
        push_word(STATUS_DISABLED, 8'sd0, 1'b1, 1'b1);
        push_word(STATUS_READY, 8'sd8, 1'b1, 1'b1);
        push_word(STATUS_SWON, 8'sd8, 1'b1, 1'b1);
        push_word(STATUS_ENABLED, 8'sd8, 1'b1, 1'b1);
        push_word(STATUS_ENABLED, 8'sd8, 1'b1, 1'b1);
        push_word(STATUS_ENABLED, 8'sd9, 1'b1, 1'b1);
        push_word(STATUS_ENABLED, 8'sd10, 1'b1, 1'b1);
        push_word(STATUS_ENABLED, 8'sd10, 1'b1, 1'b0);
        push_word(STATUS_QSTOP, 8'sd10, 1'b1, 1'b1);
        push_word(16'h0003, 8'sd10, 1'b1, 1'b1);
        push_word(16'h0005, 8'sd10, 1'b1, 1'b1);
        push_word(16'h0004, 8'sd10, 1'b1, 1'b1);
        push_word(16'h0028, 8'sd10, 1'b1, 1'b1);
        push_word(16'h0028, 8'sd10, 1'b1, 1'b1);
        push_word(16'h0060, 8'sd10, 1'b0, 1'b1);
        push_word(16'h0000, 8'sd10, 1'b0, 1'b1);
        wait_idle();

        run_random_phase('{1'b0, 1'b1, 8'sd9, 1'b1}, 140, 1'b0, 1'b0);
        run_random_phase('{1'b1, 1'b1, 8'sd10, 1'b0}, 140, 1'b0, 1'b1);
        run_random_phase('{1'b0, 1'b0, -8'sd1, 1'b1}, 100, 1'b0, 1'b0);
        run_random_phase('{1'b1, 1'b1, 8'sd127, 1'b1}, 120, 1'b1, 1'b0);
        run_random_phase('{1'b0, 1'b1, 8'sd0, 1'b1}, 140, 1'b0, 1'b0);
        run_random_phase('{1'b1, 1'b1, 8'sd11, 1'b1}, 100, 1'b0, 1'b1);
        run_random_phase('{1'b0, 1'b1, 8'sd8, 1'b0}, 140, 1'b0, 1'b0);
        run_random_phase('{1'b1, 1'b1, 8'sd7, 1'b1}, 140, 1'b0, 1'b0);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
